FILE: src/lgs_pkg.sv
// Shared types, constants and the B3/S23 rule for the Life generation stencil.
`default_nettype none

package lgs_pkg;

    // Width of the side length register and of the emitted row/column indexes
    localparam int SIDE_W = 6;
    localparam int IDX_W  = 5;

    // Side length after reset
    localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

    // Neighbor counts of the rule
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT  = 4'd2;

    // One column of both line stores
    typedef struct packed {
        logic newer;
        logic older;
    } t_line_bits;

    // Control of one line store cell
    typedef struct packed {
        logic shift;
        logic sel;
    } t_cell_ctrl;

    // One column entering the 3x3 window
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_win_col;

    // Control of the window
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctrl;

    // Next state of one cell from its live neighbor count and its own value
    function automatic logic life_rule(input logic [3:0] count, input logic center);
        logic next;
        if (count == BIRTH_COUNT) begin
            next = 1'b1;
        end else if (count == KEEP_COUNT) begin
            next = center;
        end else begin
            next = 1'b0;
        end
        return next;
    endfunction

endpackage

`default_nettype wire

FILE: src/lgs_line_cell.sv
// One cell of the line store chain: holds one column of the newer and older rows.
`default_nettype none

module lgs_line_cell
    import lgs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_line_bits i_ins,
    input  wire t_line_bits i_prev,
    output t_line_bits      o_data
);

    t_line_bits r_data;
    t_line_bits n_data;

    // Take the fresh column at the insertion point, else the left neighbor
    always_comb begin
        n_data = i_ctrl.sel ? i_ins : i_prev;
    end

    // Advance only when shift is set: on each slot that moves, except the right-edge slot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: src/lgs_window.sv
// 3x3 neighborhood window with the neighbor count and the B3/S23 rule.
`default_nettype none

module lgs_window
    import lgs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_win_ctrl i_ctrl,
    input  wire t_win_col  i_col,
    output logic           o_next,
    output logic           o_center
);

    t_win_col   r_win [3];
    logic [3:0] count;

    // Shift columns left; drop the old columns at the start of a row
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            if (i_ctrl.clear) begin
                r_win[0] <= '0;
                r_win[1] <= '0;
            end else begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
            end
            r_win[2] <= i_col;
        end
    end

    // Count the eight neighbors of the center
    always_comb begin
        count = 4'(r_win[0].top) + 4'(r_win[0].mid) + 4'(r_win[0].bot)
              + 4'(r_win[1].top) + 4'(r_win[1].bot)
              + 4'(r_win[2].top) + 4'(r_win[2].mid) + 4'(r_win[2].bot);
    end

    assign o_center = r_win[1].mid;
    assign o_next   = life_rule(count, r_win[1].mid);

endmodule

`default_nettype wire

FILE: src/life_generation_stencil.sv
// Top level of the streaming Life (B3/S23) next-generation stencil.
`default_nettype none

// Takes one generation of a square grid of side S (register side_length, 0 acts as 1,
// values above GRID_MAX act as GRID_MAX) as a raster stream of cells and returns the
// next generation in raster order, one row behind the input, with row and column
// indexes, a burst end mark, a frame end mark and, on the frame end, whether any cell
// changed. A scan sequencer walks one grid slot per cycle unless stalled: S input slots per
// row plus one right-edge slot, and after the last row one more row of S+1 slots that
// drains it with dead cells below; each slot yields at most one result, so a frame walks
// (S+1)*(S+1) slots for S*S cells. Input is stalled in the right-edge and drain slots
// and when the output is blocked. Results pass through the stage 1 register and the
// output register. The two line stores are a chain of GRID_MAX cells whose insertion
// point the side length selects; they need no clearing pass, since rows are read only
// after they are written. A register write restarts the frame at row 0, column 0.
module life_generation_stencil
    import lgs_pkg::*;
#(
    parameter int GRID_MAX = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [SIDE_W-1:0] i_cfg_wr_data,
    input  wire logic              i_valid,
    input  wire logic              i_cell_alive,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic                   o_next_alive,
    output logic [IDX_W-1:0]       o_cell_row,
    output logic [IDX_W-1:0]       o_cell_column,
    output logic                   o_end_of_burst,
    output logic                   o_end_of_frame,
    output logic                   o_frame_changed,
    input  wire logic              i_stall
);

    localparam int CW = $clog2(GRID_MAX + 1);
    localparam int AW = $clog2(GRID_MAX);
    localparam logic [CW-1:0]     GMAX_C = CW'(GRID_MAX);
    localparam logic [SIDE_W-1:0] GMAX_S = SIDE_W'(GRID_MAX);

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             eob;
        logic             eof;
    } t_tag;

    logic [SIDE_W-1:0] r_side;
    logic [CW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [CW-1:0]     n_row;
    logic [CW-1:0]     n_col;
    logic              r_s1_valid;
    t_tag              r_s1_tag;
    logic              r_o_valid;
    logic              r_o_next;
    t_tag              r_o_tag;
    logic              r_o_changed;
    logic              r_change;

    logic [CW-1:0] side;
    logic [CW-1:0] side_last;
    logic [AW-1:0] ins_idx;
    logic          phantom_col;
    logic          phantom_row;
    logic          real_pos;
    logic          out_free;
    logic          s1_free;
    logic          adv;
    logic          emit;
    t_tag          tag;

    t_line_bits chain [GRID_MAX];
    t_line_bits chain_out;
    t_line_bits line_ins;
    logic       line_shift;
    t_win_col   win_col;
    t_win_ctrl  win_ctrl;
    logic       win_next;
    logic       win_center;
    logic       diff;

    // Clamp the side length into the supported range
    always_comb begin
        if (r_side == '0) begin
            side = CW'(1);
        end else if (r_side > GMAX_S) begin
            side = GMAX_C;
        end else begin
            side = CW'(r_side);
        end
        side_last = side - CW'(1);
        ins_idx   = AW'(GMAX_C - side);
    end

    // Classify the current scan slot
    assign phantom_col = (r_col == side);
    assign phantom_row = (r_row == side);
    assign real_pos    = !phantom_col && !phantom_row;

    // Handshake: stage 1 moves when empty or when the output register frees up
    assign out_free = !r_o_valid || !i_stall;
    assign s1_free  = !r_s1_valid || out_free;
    assign adv      = s1_free && (!real_pos || i_valid);
    assign o_stall  = !(s1_free && real_pos);

    // Next scan slot
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (phantom_col) begin
            n_col = '0;
            n_row = phantom_row ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // Result tag of this slot: the window center sits one row up and one column left
    always_comb begin
        emit    = (r_row != '0) && (r_col != '0);
        tag.row = IDX_W'(r_row - CW'(1));
        tag.col = IDX_W'(r_col - CW'(1));
        if (phantom_col) begin
            tag.eob = (r_row != side_last);
        end else begin
            tag.eob = !phantom_row && (r_col != side_last);
        end
        tag.eof = phantom_row && phantom_col;
    end

    // Line store chain: newer row from the input, older row from the chain end
    assign chain_out      = chain[GRID_MAX-1];
    assign line_shift     = adv && !phantom_col;
    assign line_ins.newer = phantom_row ? 1'b0 : i_cell_alive;
    assign line_ins.older = chain_out.newer;

    for (genvar j = 0; j < GRID_MAX; j++) begin : g_cell
        t_cell_ctrl cell_ctrl;
        t_line_bits prev;
        assign cell_ctrl.shift = line_shift;
        assign cell_ctrl.sel   = (ins_idx == AW'(j));
        if (j == 0) begin : g_first
            assign prev = '0;
        end else begin : g_next
            assign prev = chain[j-1];
        end
        lgs_line_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (cell_ctrl),
            .i_ins  (line_ins),
            .i_prev (prev),
            .o_data (chain[j])
        );
    end

    // Column entering the window; rows not yet written read as dead
    always_comb begin
        win_col = '0;
        if (!phantom_col) begin
            win_col.top = (r_row >= CW'(2)) ? chain_out.older : 1'b0;
            win_col.mid = (r_row != '0) ? chain_out.newer : 1'b0;
            win_col.bot = phantom_row ? 1'b0 : i_cell_alive;
        end
        win_ctrl.shift = adv;
        win_ctrl.clear = (r_col == '0);
    end

    lgs_window u_window (
        .i_clk    (i_clk),
        .i_ctrl   (win_ctrl),
        .i_col    (win_col),
        .o_next   (win_next),
        .o_center (win_center)
    );

    assign diff = win_next ^ win_center;

    // Control: configuration, scan counters, stage valids and change flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= SIDE_RESET;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_change   <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= adv && emit;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
            if (i_cfg_wr_en) begin
                r_side   <= i_cfg_wr_data;
                r_row    <= '0;
                r_col    <= '0;
                r_change <= 1'b0;
            end else begin
                if (out_free && r_s1_valid) begin
                    r_change <= r_s1_tag.eof ? 1'b0 : (r_change | diff);
                end
                if (adv) begin
                    r_row <= n_row;
                    r_col <= n_col;
                end
            end
        end
    end

    // Payload: hold the slot tag, then the finished result
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_tag <= tag;
        end
        if (out_free && r_s1_valid) begin
            r_o_next    <= win_next;
            r_o_tag     <= r_s1_tag;
            r_o_changed <= r_s1_tag.eof && (r_change | diff);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_next_alive    = r_o_next;
    assign o_cell_row      = r_o_tag.row;
    assign o_cell_column   = r_o_tag.col;
    assign o_end_of_burst  = r_o_tag.eob;
    assign o_end_of_frame  = r_o_tag.eof;
    assign o_frame_changed = r_o_changed;

endmodule

`default_nettype wire

FILE: src/lgs_checker.sv
// Port-level checks of the Life stencil and the bind that attaches them.
`default_nettype none

module lgs_checker
    import lgs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_stall,
    input wire logic             o_valid,
    input wire logic             o_next_alive,
    input wire logic [IDX_W-1:0] o_cell_row,
    input wire logic [IDX_W-1:0] o_cell_column,
    input wire logic             o_end_of_burst,
    input wire logic             o_end_of_frame,
    input wire logic             o_frame_changed,
    input wire logic             i_stall
);

    // A stalled result beat stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_next_alive, o_cell_row,
            o_cell_column, o_end_of_burst, o_end_of_frame, o_frame_changed}))
        else $error("stalled result beat changed");

    // The frame end closes its burst
    a_eof_eob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_frame |-> o_end_of_burst)
        else $error("frame end without burst end");

    // The change flag shows only on the frame end
    a_changed_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_changed |-> o_end_of_frame)
        else $error("change flag outside frame end");

    // The last cell of a square grid lies on the diagonal
    a_eof_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_frame |-> o_cell_row == o_cell_column)
        else $error("frame end off the grid corner");

    // Reset empties the pipeline and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .o_next_alive    (o_next_alive),
    .o_cell_row      (o_cell_row),
    .o_cell_column   (o_cell_column),
    .o_end_of_burst  (o_end_of_burst),
    .o_end_of_frame  (o_end_of_frame),
    .o_frame_changed (o_frame_changed),
    .i_stall         (i_stall)
);

`default_nettype wire

FILE: tb/life_generation_stencil_checker.sv
// Checker for the Life generation stencil: predicts each next generation and compares results.
`default_nettype none

module life_generation_stencil_checker
    import lgs_pkg::*;
#(
    parameter int GRID_MAX = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [SIDE_W-1:0] i_cfg_wr_data,
    input  wire logic              i_valid,
    input  wire logic              i_cell_alive,
    input  wire logic              i_in_stall,
    input  wire logic              i_out_valid,
    input  wire logic              i_next_alive,
    input  wire logic [IDX_W-1:0]  i_cell_row,
    input  wire logic [IDX_W-1:0]  i_cell_column,
    input  wire logic              i_end_of_burst,
    input  wire logic              i_end_of_frame,
    input  wire logic              i_frame_changed,
    input  wire logic              i_out_stall,
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // One emitted cell of the next generation
    typedef struct packed {
        logic             alive;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] column;
        logic             burst_end;
        logic             frame_end;
        logic             changed;
    } t_next_cell;

    // Predicted grid state: two rows of history, raster position, 3x3 window
    logic [GRID_MAX-1:0] older_row;
    logic [GRID_MAX-1:0] newer_row;
    int                  row_at;
    int                  column_at;
    logic                changed_so_far;
    logic [SIDE_W-1:0]   side_setting;
    logic [2:0]          window [3];     // bit 2 holds the newest column

    // Cells released by one input beat, then the queue of cells still owed
    t_next_cell          step_cells [GRID_MAX+2];
    int                  step_count;
    t_next_cell          next_cells_q [$];

    int                  mismatch_count = 0;
    int                  result_count   = 0;

    // B3/S23: birth on three neighbors, survival on two or three
    function automatic logic b3s23(input int count, input logic center);
        if (count == int'(BIRTH_COUNT)) return 1'b1;
        if (count == int'(KEEP_COUNT)) return center;
        return 1'b0;
    endfunction

    task automatic clear_window();
        window[0] = '0;
        window[1] = '0;
        window[2] = '0;
    endtask

    task automatic shift_window(input logic top, input logic mid, input logic bot);
        window[0] = {top, window[0][2:1]};
        window[1] = {mid, window[1][2:1]};
        window[2] = {bot, window[2][2:1]};
    endtask

    // Append one cell to this beat's results and track whether it changed
    task automatic add_cell(input int count, input logic center, input int row, input int column);
        t_next_cell emitted;
        emitted        = '0;
        emitted.alive  = b3s23(count, center);
        emitted.row    = IDX_W'(row);
        emitted.column = IDX_W'(column);
        changed_so_far = changed_so_far | (emitted.alive ^ center);
        step_cells[step_count] = emitted;
        step_count++;
    endtask

    // Emit the window center with its eight neighbors
    task automatic add_window_cell(input int row, input int column);
        int count;
        count = $countones({window[0], window[1], window[2]}) - int'(window[1][1]);
        add_cell(count, window[1][1], row, column);
    endtask

    task automatic report_field(input string field, input logic [IDX_W-1:0] want,
                                input logic [IDX_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_next_cell seen;
        t_next_cell want;
        int         side;
        int         r;
        int         c;
        int         count;
        int         k;
        int         j;
        logic       top;
        logic       mid;
        if (!i_rst_n) begin
            older_row      = '0;
            newer_row      = '0;
            row_at         = 0;
            column_at      = 0;
            changed_so_far = 1'b0;
            side_setting   = SIDE_RESET;
            clear_window();
        end else begin
            // Compare the beat leaving the block with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                seen.alive     = i_next_alive;
                seen.row       = i_cell_row;
                seen.column    = i_cell_column;
                seen.burst_end = i_end_of_burst;
                seen.frame_end = i_end_of_frame;
                seen.changed   = i_frame_changed;
                result_count++;
                if (next_cells_q.size() == 0) begin
                    $display("%0t: result expected none, got row %0d column %0d alive %0b",
                             $time, seen.row, seen.column, seen.alive);
                    mismatch_count++;
                end else begin
                    want = next_cells_q.pop_front();
                    report_field("next_alive", IDX_W'(want.alive), IDX_W'(seen.alive));
                    report_field("cell_row", want.row, seen.row);
                    report_field("cell_column", want.column, seen.column);
                    report_field("end_of_burst", IDX_W'(want.burst_end),
                                 IDX_W'(seen.burst_end));
                    report_field("end_of_frame", IDX_W'(want.frame_end),
                                 IDX_W'(seen.frame_end));
                    report_field("frame_changed", IDX_W'(want.changed),
                                 IDX_W'(seen.changed));
                end
            end

            // A side length write restarts the frame
            if (i_cfg_wr_en) begin
                side_setting   = i_cfg_wr_data;
                row_at         = 0;
                column_at      = 0;
                changed_so_far = 1'b0;
                clear_window();
            end

            // Predict the cells this input beat releases
            if (i_valid && !i_in_stall) begin
                side = int'(side_setting);
                if (side < 1) side = 1;
                if (side > GRID_MAX) side = GRID_MAX;
                r = row_at;
                c = column_at;
                if (r >= side || c >= side) begin
                    r              = 0;
                    c              = 0;
                    changed_so_far = 1'b0;
                end
                if (c == 0) clear_window();

                // Rows above are only used once they hold this frame's data
                top = (r >= 2) ? older_row[c] : 1'b0;
                mid = (r >= 1) ? newer_row[c] : 1'b0;
                shift_window(top, mid, i_cell_alive);
                older_row[c] = newer_row[c];
                newer_row[c] = i_cell_alive;

                step_count = 0;
                if (r >= 1 && c >= 1) add_window_cell(r - 1, c - 1);
                // Right edge: flush the row's last cell with dead cells beyond it
                if (r >= 1 && c == side - 1 && c >= 1) begin
                    shift_window(1'b0, 1'b0, 1'b0);
                    add_window_cell(r - 1, c);
                end

                // Last cell of the frame: flush the whole bottom row
                if (r == side - 1 && c == side - 1) begin
                    for (k = 0; k < side; k++) begin
                        count = 0;
                        for (j = (k == 0) ? 0 : k - 1; j <= k + 1 && j < side; j++) begin
                            if (r >= 1) count += int'(older_row[j]);
                            if (j != k) count += int'(newer_row[j]);
                        end
                        add_cell(count, newer_row[k], r, k);
                    end
                    step_cells[step_count-1].frame_end = 1'b1;
                    step_cells[step_count-1].changed   = changed_so_far;
                    changed_so_far = 1'b0;
                end

                if (step_count > 0) step_cells[step_count-1].burst_end = 1'b1;
                for (k = 0; k < step_count; k++) next_cells_q.push_back(step_cells[k]);

                // Advance the raster position
                c++;
                if (c >= side) begin
                    c = 0;
                    r++;
                    if (r >= side) r = 0;
                end
                row_at    = r;
                column_at = c;
            end
        end
        o_pending    <= next_cells_q.size();
        o_mismatches <= mismatch_count;
        o_results    <= result_count;
    end

endmodule

`default_nettype wire

FILE: tb/life_generation_stencil_tb.sv
// Testbench top for the Life generation stencil: clock, reset, stimulus and verdict.
`default_nettype none

module life_generation_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lgs_pkg::*;

    localparam int GRID_MAX      = 32;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 2 * (GRID_MAX + 2) + 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_CELLS  = 64;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [SIDE_W-1:0] i_cfg_wr_data;
    logic              i_valid;
    logic              i_cell_alive;
    logic              i_stall;
    logic              o_stall;
    logic              o_valid;
    logic              o_next_alive;
    logic [IDX_W-1:0]  o_cell_row;
    logic [IDX_W-1:0]  o_cell_column;
    logic              o_end_of_burst;
    logic              o_end_of_frame;
    logic              o_frame_changed;

    int                mismatch_total;
    int                pending_cells;
    int                results_checked;

    int                burst_left    = 0;
    int                cells_sent    = 0;
    int                side_writes   = 0;
    int                cycle_count   = 0;
    bit                hold_request  = 1'b0;

    life_generation_stencil #(
        .GRID_MAX (GRID_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .i_cell_alive    (i_cell_alive),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .o_next_alive    (o_next_alive),
        .o_cell_row      (o_cell_row),
        .o_cell_column   (o_cell_column),
        .o_end_of_burst  (o_end_of_burst),
        .o_end_of_frame  (o_end_of_frame),
        .o_frame_changed (o_frame_changed),
        .i_stall         (i_stall)
    );

    life_generation_stencil_checker #(
        .GRID_MAX (GRID_MAX)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .i_cell_alive    (i_cell_alive),
        .i_in_stall      (o_stall),
        .i_out_valid     (o_valid),
        .i_next_alive    (o_next_alive),
        .i_cell_row      (o_cell_row),
        .i_cell_column   (o_cell_column),
        .i_end_of_burst  (o_end_of_burst),
        .i_end_of_frame  (o_end_of_frame),
        .i_frame_changed (o_frame_changed),
        .i_out_stall     (i_stall),
        .o_mismatches    (mismatch_total),
        .o_pending       (pending_cells),
        .o_results       (results_checked)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one cell; bursts of random length with random gaps in between
    task automatic send_cell(input logic alive);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_valid      <= 1'b1;
        i_cell_alive <= alive;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        cells_sent++;
    endtask

    // Offer a run of cells, each live with the given percent chance
    task automatic send_cells(input int count, input int density);
        int k;
        for (k = 0; k < count; k++) send_cell($urandom_range(0, 99) < density);
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cells != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        side_writes++;
    endtask

    // Receiver: stall modes of random length, plus one long hold when requested
    initial begin : receiver
        int mode;
        int run;
        int k;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(16, 96);
            for (k = 0; k < run; k++) begin
                @(posedge i_clk);
                if (hold_request) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ((k % 5) < 2);
                endcase
            end
        end
    end

    initial begin : stimulus
        int side;
        int frames;
        int density;
        int f;
        int random_start;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_cell_alive  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero side acts as a one-cell grid: a live cell dies, a dead one stays
        write_side(6'd0);
        send_cell(1'b1);
        send_cell(1'b0);
        settle();
        write_side(6'd1);
        send_cell(1'b1);
        settle();

        // Vertical blinker on 3x3 turns horizontal
        write_side(6'd3);
        send_cell(1'b0); send_cell(1'b1); send_cell(1'b0);
        send_cell(1'b0); send_cell(1'b1); send_cell(1'b0);
        send_cell(1'b0); send_cell(1'b1); send_cell(1'b0);
        settle();

        // Full 2x2 block is a still life: no change reported
        write_side(6'd2);
        repeat (4) send_cell(1'b1);
        settle();

        // Leave a frame half done; the next write restarts it
        write_side(6'd3);
        send_cell(1'b1); send_cell(1'b1); send_cell(1'b1); send_cell(1'b0);
        settle();

        // Oversized side saturates; long output hold lets the block back up
        write_side(6'd40);
        hold_request = 1'b1;
        send_cells(70, 40);
        settle();
        write_side(6'd63);
        send_cells(34, 50);
        settle();
        write_side(6'd32);
        send_cells(34, 30);
        settle();

        // Random small grids: whole frames back to back, sometimes cut short
        random_start = cells_sent;
        while (cells_sent - random_start < RANDOM_CELLS) begin
            side = $urandom_range(1, 7);
            write_side(SIDE_W'(side));
            frames = $urandom_range(1, 2);
            if (frames * side * side > RANDOM_CELLS - (cells_sent - random_start))
                frames = 1;
            for (f = 0; f < frames; f++) begin
                case ($urandom_range(0, 5))
                    0:       density = 0;
                    1:       density = 100;
                    default: density = $urandom_range(15, 60);
                endcase
                send_cells(side * side, density);
            end
            if (side > 1 && $urandom_range(0, 3) == 0)
                send_cells($urandom_range(1, side * side - 1), 40);
            settle();
        end

        $display("Run fed %0d cells under %0d side writes (zero, 1 to 7, 32 and saturating),",
                 cells_sent, side_writes);
        $display("with mid-frame restarts and a %0d-cycle output hold; %0d results checked.",
                 HOLD_CYCLES, results_checked);
        if (mismatch_total == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: life_generation_stencil.f
src/lgs_pkg.sv
src/lgs_line_cell.sv
src/lgs_window.sv
src/life_generation_stencil.sv
src/lgs_checker.sv
tb/life_generation_stencil_checker.sv
tb/life_generation_stencil_tb.sv
